### rtl/cba_pkg.sv
// shared types and constants of the clustered block allocator
// no dependencies; imported by every other file of the block but cba_ram
`default_nettype none

package cba_pkg;

    localparam int DEF_MAX_BLOCKS    = 128;
    localparam int RESET_BLOCK_COUNT = 128;
    localparam int FIELD_W           = 8;
    localparam int ENTRY_W           = FIELD_W + 1;

    localparam logic OP_ALLOC    = 1'b0;
    localparam logic OP_FREE     = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_POST
    } cba_state_t;

    typedef struct packed {
        logic start;
        logic clear_en;
        logic scan_en;
        logic load_out;
    } cba_cmd_t;

    typedef struct packed {
        logic skip;
        logic scan_done;
        logic clear_done;
        logic out_free;
    } cba_sts_t;

endpackage

`default_nettype wire

### rtl/cba_req_if.sv
// request channel: valid/ready handshake with op, owner and block count
// depends on cba_pkg
`default_nettype none

interface cba_req_if
    import cba_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               op;
    logic [FIELD_W-1:0] owner;
    logic [FIELD_W-1:0] num_blocks;

    modport source (output valid, output op, output owner, output num_blocks, input ready);
    modport sink   (input valid, input op, input owner, input num_blocks, output ready);
endinterface

`default_nettype wire

### rtl/cba_rsp_if.sv
// result channel: valid/ready handshake with status and counts
// depends on cba_pkg
`default_nettype none

interface cba_rsp_if
    import cba_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               status;
    logic [FIELD_W-1:0] clusters;
    logic [FIELD_W-1:0] freed;
    logic [FIELD_W-1:0] free_left;

    modport source (output valid, output status, output clusters, output freed,
                     output free_left, input ready);
    modport sink   (input valid, input status, input clusters, input freed,
                     input free_left, output ready);
endinterface

`default_nettype wire

### rtl/cba_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module cba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/cba_ctrl.sv
// controller state machine: clearing pass, idle, map scan, result load
// depends on cba_pkg
`default_nettype none

module cba_ctrl
    import cba_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cfg_we,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire cba_sts_t sts,
    output cba_cmd_t      cmd
);

    cba_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (!cfg_we && sts.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = !cfg_we;
                if (cfg_we)
                begin
                    state_next = S_CLEAR;
                end
                else if (req_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = sts.skip ? S_POST : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/cba_dp.sv
// datapath: owner map ram, scan index, counters and result register
// depends on cba_pkg and cba_ram
`default_nettype none

module cba_dp
    import cba_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [FIELD_W-1:0] cfg_data,
    input  wire logic               op,
    input  wire logic [FIELD_W-1:0] owner,
    input  wire logic [FIELD_W-1:0] num_blocks,
    input  wire cba_cmd_t           cmd,
    output cba_sts_t                sts,
    cba_rsp_if.source               rsp
);

    localparam int AW    = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int RESET_BLOCKS =
        (RESET_BLOCK_COUNT > MAX_BLOCKS) ? MAX_BLOCKS : RESET_BLOCK_COUNT;

    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [AW-1:0]      rd_idx_reg, rd_idx_next;
    logic               rd_valid_reg, rd_valid_next;
    logic               stop_reg, stop_next;
    logic [CNT_W-1:0]   blocks_reg, blocks_next;
    logic [CNT_W-1:0]   free_count_reg, free_count_next;
    logic               op_reg;
    logic [FIELD_W-1:0] owner_reg;
    logic [FIELD_W-1:0] left_reg, left_next;
    logic               run_open_reg, run_open_next;
    logic [CNT_W-1:0]   clusters_reg, clusters_next;
    logic [CNT_W-1:0]   freed_reg, freed_next;
    logic               status_reg;
    logic               out_valid_reg;
    logic               out_status_reg;
    logic [FIELD_W-1:0] out_clusters_reg, out_freed_reg, out_free_left_reg;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    logic               ent_valid;
    logic [FIELD_W-1:0] ent_owner;
    logic               proc, issue, alloc_last, full;
    logic [31:0]        cfg_ext;
    logic [CNT_W-1:0]   cfg_blocks;

    cba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BLOCKS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign ent_valid = ram_rdata[ENTRY_W-1];
    assign ent_owner = ram_rdata[FIELD_W-1:0];

    // saturate the written block count
    always_comb
    begin
        cfg_ext = 32'(cfg_data);
        if (cfg_ext > 32'(MAX_BLOCKS))
        begin
            cfg_blocks = CNT_W'(MAX_BLOCKS);
        end
        else
        begin
            cfg_blocks = CNT_W'(cfg_ext);
        end
    end

    assign full     = (32'(num_blocks) > 32'(free_count_reg));
    assign sts.skip = (op == OP_ALLOC) && (full || (num_blocks == '0));

    assign proc       = cmd.scan_en && rd_valid_reg && !stop_reg;
    assign alloc_last = proc && (op_reg == OP_ALLOC) && !ent_valid
                        && (left_reg == FIELD_W'(1));
    assign issue      = cmd.scan_en && (idx_reg < blocks_reg) && !stop_reg && !alloc_last;

    assign sts.scan_done  = stop_reg || ((idx_reg >= blocks_reg) && !rd_valid_reg);
    assign sts.clear_done = (idx_reg == CNT_W'(MAX_BLOCKS - 1));
    assign sts.out_free   = !out_valid_reg || rsp.ready;

    always_comb
    begin
        idx_next        = idx_reg;
        rd_idx_next     = idx_reg[AW-1:0];
        rd_valid_next   = issue;
        stop_next       = stop_reg;
        blocks_next     = blocks_reg;
        free_count_next = free_count_reg;
        left_next       = left_reg;
        run_open_next   = run_open_reg;
        clusters_next   = clusters_reg;
        freed_next      = freed_reg;
        ram_we          = 1'b0;
        ram_waddr       = rd_idx_reg;
        ram_wdata       = '0;

        if (cfg_we)
        begin
            blocks_next     = cfg_blocks;
            free_count_next = cfg_blocks;
            idx_next        = '0;
        end
        else if (cmd.clear_en)
        begin
            ram_we    = 1'b1;
            ram_waddr = idx_reg[AW-1:0];
            idx_next  = idx_reg + CNT_W'(1);
        end
        else if (cmd.start)
        begin
            idx_next      = '0;
            stop_next     = 1'b0;
            left_next     = num_blocks;
            run_open_next = 1'b0;
            clusters_next = '0;
            freed_next    = '0;
        end
        else if (cmd.scan_en)
        begin
            if (issue)
            begin
                idx_next = idx_reg + CNT_W'(1);
            end
            if (alloc_last)
            begin
                stop_next = 1'b1;
            end
            if (proc)
            begin
                if (op_reg == OP_ALLOC)
                begin
                    if (!ent_valid)
                    begin
                        ram_we          = 1'b1;
                        ram_wdata       = {1'b1, owner_reg};
                        free_count_next = free_count_reg - CNT_W'(1);
                        left_next       = left_reg - FIELD_W'(1);
                        run_open_next   = 1'b1;
                        if (!run_open_reg)
                        begin
                            clusters_next = clusters_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        run_open_next = 1'b0;
                    end
                end
                else if (ent_valid && (ent_owner == owner_reg))
                begin
                    ram_we          = 1'b1;
                    ram_wdata       = '0;
                    free_count_next = free_count_reg + CNT_W'(1);
                    freed_next      = freed_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            rd_valid_reg   <= 1'b0;
            stop_reg       <= 1'b0;
            blocks_reg     <= CNT_W'(RESET_BLOCKS);
            free_count_reg <= CNT_W'(RESET_BLOCKS);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            idx_reg        <= idx_next;
            rd_valid_reg   <= rd_valid_next;
            stop_reg       <= stop_next;
            blocks_reg     <= blocks_next;
            free_count_reg <= free_count_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= rd_idx_next;
        left_reg      <= left_next;
        run_open_reg  <= run_open_next;
        clusters_reg  <= clusters_next;
        freed_reg     <= freed_next;
        if (cmd.start)
        begin
            op_reg     <= op;
            owner_reg  <= owner;
            status_reg <= (op == OP_ALLOC) && full ? STATUS_FULL : STATUS_OK;
        end
        if (cmd.load_out)
        begin
            out_status_reg    <= status_reg;
            out_clusters_reg  <= FIELD_W'(clusters_reg);
            out_freed_reg     <= FIELD_W'(freed_reg);
            out_free_left_reg <= FIELD_W'(free_count_reg);
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.clusters  = out_clusters_reg;
    assign rsp.freed     = out_freed_reg;
    assign rsp.free_left = out_free_left_reg;

endmodule

`default_nettype wire

### rtl/clustered_block_allocator_unit.sv
// a scanned request is accepted in idle, walks the managed blocks through the registered
// owner map read, then loads the result register once it is free
// full or zero-block allocates skip the scan; one request at a time, so a new request
// is taken only after the last result is loaded into the result register
// after reset and after a block count write in idle or clearing, a clearing pass over all
// MAX_BLOCKS entries sweeps the owner map with ready low
`default_nettype none

module clustered_block_allocator_unit
    import cba_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [FIELD_W-1:0] cfg_wdata,
    cba_req_if.sink                 req,
    cba_rsp_if.source               rsp
);

    cba_cmd_t cmd;
    cba_sts_t sts;

    cba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    cba_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_wdata),
        .op         (req.op),
        .owner      (req.owner),
        .num_blocks (req.num_blocks),
        .cmd        (cmd),
        .sts        (sts),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

### rtl/cba_checker.sv
// port-level checks of the allocator and the bind that attaches them
// depends on cba_pkg and clustered_block_allocator_unit
`default_nettype none

module cba_checker
    import cba_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               req_valid,
    input wire logic               req_ready,
    input wire logic               rsp_valid,
    input wire logic               rsp_ready,
    input wire logic               rsp_status,
    input wire logic [FIELD_W-1:0] rsp_clusters,
    input wire logic [FIELD_W-1:0] rsp_freed
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped before transfer");

    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == STATUS_FULL) |-> (rsp_clusters == '0) && (rsp_freed == '0))
        else $error("full result carries counts");

    a_alloc_no_freed: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_clusters != '0) |-> (rsp_freed == '0))
        else $error("allocate result reports freed blocks");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in work");

endmodule

bind clustered_block_allocator_unit cba_checker u_cba_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_status   (rsp.status),
    .rsp_clusters (rsp.clusters),
    .rsp_freed    (rsp.freed)
);

`default_nettype wire

### test/tb_clustered_block_allocator_unit.sv
`timescale 1ns / 100ps
// self-checking bench for clustered_block_allocator_unit: a directed table, then random
// allocate and free traffic under several block counts and idle patterns
// depends on cba_pkg, cba_req_if, cba_rsp_if and the unit itself

module tb_clustered_block_allocator_unit;
    import cba_pkg::*;

    localparam int MAP_SIZE     = DEF_MAX_BLOCKS;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = MAP_SIZE + 16;
    localparam int NUM_DIRECTED = 23;
    localparam int NUM_PHASES   = 9;
    localparam int POOL_SIZE    = 5;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic               status;
        logic [FIELD_W-1:0] clusters;
        logic [FIELD_W-1:0] freed;
        logic [FIELD_W-1:0] free_left;
    } alloc_result_t;

    typedef struct packed {
        logic               op;
        logic [FIELD_W-1:0] owner;
        logic [FIELD_W-1:0] need;
        logic               typed;
        alloc_result_t      want;
    } request_row_t;

    localparam alloc_result_t NO_WANT = '0;

    // rows marked typed carry the result expected straight after reset
    request_row_t directed_rows [NUM_DIRECTED] = '{
        '{OP_ALLOC, 8'h00, 8'd0,   1'b1, '{STATUS_OK,   8'd0, 8'd0, 8'd128}},
        '{OP_ALLOC, 8'hFF, 8'd255, 1'b1, '{STATUS_FULL, 8'd0, 8'd0, 8'd128}},
        '{OP_ALLOC, 8'hFF, 8'd129, 1'b1, '{STATUS_FULL, 8'd0, 8'd0, 8'd128}},
        '{OP_FREE,  8'h00, 8'd0,   1'b1, '{STATUS_OK,   8'd0, 8'd0, 8'd128}},
        '{OP_FREE,  8'hFF, 8'd255, 1'b1, '{STATUS_OK,   8'd0, 8'd0, 8'd128}},
        '{OP_ALLOC, 8'hA5, 8'd3,   1'b0, NO_WANT},
        '{OP_ALLOC, 8'h5A, 8'd2,   1'b0, NO_WANT},
        '{OP_ALLOC, 8'hA5, 8'd4,   1'b0, NO_WANT},
        '{OP_FREE,  8'h5A, 8'd0,   1'b0, NO_WANT},
        '{OP_ALLOC, 8'h3C, 8'd5,   1'b0, NO_WANT},
        '{OP_ALLOC, 8'h00, 8'd1,   1'b0, NO_WANT},
        '{OP_FREE,  8'h00, 8'd0,   1'b0, NO_WANT},
        '{OP_FREE,  8'hA5, 8'd0,   1'b0, NO_WANT},
        '{OP_ALLOC, 8'h81, 8'd127, 1'b0, NO_WANT},
        '{OP_FREE,  8'h3C, 8'd0,   1'b0, NO_WANT},
        '{OP_ALLOC, 8'hFF, 8'd128, 1'b0, NO_WANT},
        '{OP_ALLOC, 8'h42, 8'd1,   1'b0, NO_WANT},
        '{OP_ALLOC, 8'h42, 8'd0,   1'b0, NO_WANT},
        '{OP_FREE,  8'h42, 8'd0,   1'b0, NO_WANT},
        '{OP_FREE,  8'hFF, 8'd0,   1'b0, NO_WANT},
        '{OP_ALLOC, 8'h7E, 8'd128, 1'b0, NO_WANT},
        '{OP_FREE,  8'h7E, 8'd128, 1'b0, NO_WANT},
        '{OP_ALLOC, 8'h01, 8'd1,   1'b0, NO_WANT}
    };

    // last phase uses a block count drawn at run time
    idle_mode_t phase_mode [NUM_PHASES] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
        IDLE_NONE, IDLE_BOTH, IDLE_RECEIVER, IDLE_SENDER, IDLE_BOTH};
    int phase_blocks [NUM_PHASES] = '{1, 128, 255, 0, 7, 2, 64, 128, 0};
    int phase_items  [NUM_PHASES] = '{60, 400, 300, 40, 250, 250, 250, 200, 250};

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [FIELD_W-1:0] cfg_wdata;

    cba_req_if req_ch ();
    cba_rsp_if rsp_ch ();

    clustered_block_allocator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    bit                 slot_used [MAP_SIZE];
    logic [FIELD_W-1:0] slot_owner [MAP_SIZE];
    int unsigned        free_blocks;
    int unsigned        managed_blocks;
    alloc_result_t      expected_results [$];
    logic [FIELD_W-1:0] owner_pool [POOL_SIZE];

    int fail_count    = 0;
    int idle_cycles   = 0;
    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic alloc_result_t apply_request(logic op, logic [FIELD_W-1:0] owner,
                                                    logic [FIELD_W-1:0] need);
        alloc_result_t r;
        int unsigned   remaining;
        bit            in_run;
        r         = '0;
        r.status  = STATUS_OK;
        remaining = 32'(need);
        in_run    = 1'b0;
        if (op == OP_ALLOC)
        begin
            if (32'(need) > free_blocks)
                r.status = STATUS_FULL;
            else if (need != '0)
            begin
                for (int i = 0; i < managed_blocks; i++)
                begin
                    if (!slot_used[i])
                    begin
                        slot_used[i]  = 1'b1;
                        slot_owner[i] = owner;
                        free_blocks   = free_blocks - 1;
                        remaining     = remaining - 1;
                        if (!in_run)
                            r.clusters = r.clusters + FIELD_W'(1);
                        in_run = 1'b1;
                    end
                    else
                        in_run = 1'b0;
                    if (remaining == 0)
                        break;
                end
            end
        end
        else
        begin
            for (int i = 0; i < managed_blocks; i++)
            begin
                if (slot_used[i] && slot_owner[i] == owner)
                begin
                    slot_used[i]  = 1'b0;
                    slot_owner[i] = '0;
                    free_blocks   = free_blocks + 1;
                    r.freed       = r.freed + FIELD_W'(1);
                end
            end
        end
        r.free_left = free_blocks[FIELD_W-1:0];
        return r;
    endfunction

    task automatic send_request(logic op, logic [FIELD_W-1:0] owner, logic [FIELD_W-1:0] need,
                                bit typed, alloc_result_t want);
        int            gap;
        alloc_result_t predicted;
        gap = 0;
        while ($urandom_range(0, 99) < snd_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.op         <= op;
        req_ch.owner      <= owner;
        req_ch.num_blocks <= need;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = apply_request(op, owner, need);
        expected_results.push_back(typed ? want : predicted);
    endtask

    task automatic write_block_count(logic [FIELD_W-1:0] value);
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we         <= 1'b0;
        managed_blocks  = (32'(value) > MAP_SIZE) ? MAP_SIZE : 32'(value);
        free_blocks     = managed_blocks;
        for (int i = 0; i < MAP_SIZE; i++)
        begin
            slot_used[i]  = 1'b0;
            slot_owner[i] = '0;
        end
    endtask

    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);

    always @(posedge clk)
    begin : result_check
        alloc_result_t want;
        alloc_result_t got;
        got = '{rsp_ch.status, rsp_ch.clusters, rsp_ch.freed, rsp_ch.free_left};
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: status=%0d clusters=%0d freed=%0d free_left=%0d",
                             got.status, got.clusters, got.freed, got.free_left);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.status != want.status || got.clusters != want.clusters ||
                    got.freed != want.freed || got.free_left != want.free_left)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("mismatch: exp status=%0d clusters=%0d freed=%0d free_left=%0d",
                                 want.status, want.clusters, want.freed, want.free_left);
                        $display("          got status=%0d clusters=%0d freed=%0d free_left=%0d",
                                 got.status, got.clusters, got.freed, got.free_left);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[clustered_block_allocator_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        int                 pick;
        int                 blocks;
        logic               op;
        logic [FIELD_W-1:0] owner;
        logic [FIELD_W-1:0] need;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        req_ch.valid      = 1'b0;
        req_ch.op         = OP_ALLOC;
        req_ch.owner      = '0;
        req_ch.num_blocks = '0;
        managed_blocks    = RESET_BLOCK_COUNT;
        free_blocks       = RESET_BLOCK_COUNT;
        for (int i = 0; i < MAP_SIZE; i++)
        begin
            slot_used[i]  = 1'b0;
            slot_owner[i] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < NUM_DIRECTED; k++)
            send_request(directed_rows[k].op, directed_rows[k].owner, directed_rows[k].need,
                         directed_rows[k].typed, directed_rows[k].want);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            snd_idle_pct  = (phase_mode[p] == IDLE_SENDER) ? 74 :
                            (phase_mode[p] == IDLE_BOTH) ? 9 : 0;
            rcv_stall_pct = (phase_mode[p] == IDLE_RECEIVER) ? 74 :
                            (phase_mode[p] == IDLE_BOTH) ? 9 : 0;
            blocks = (p == NUM_PHASES - 1) ? int'($urandom_range(3, 126)) : phase_blocks[p];
            write_block_count(blocks[FIELD_W-1:0]);
            for (int k = 0; k < POOL_SIZE; k++)
                owner_pool[k] = FIELD_W'($urandom_range(0, 255));
            for (int n = 0; n < phase_items[p]; n++)
            begin
                pick  = int'($urandom_range(0, 99));
                op    = OP_ALLOC;
                owner = owner_pool[$urandom_range(0, POOL_SIZE - 1)];
                need  = '0;
                if (pick < 45)
                begin
                    need = FIELD_W'($urandom_range(1, managed_blocks / 4 + 1));
                    if ($urandom_range(0, 9) == 0)
                        need = free_blocks[FIELD_W-1:0];
                end
                else if (pick < 80)
                begin
                    op   = OP_FREE;
                    need = FIELD_W'($urandom_range(0, 255));
                end
                else if (pick < 93 && pick >= 86)
                    need = FIELD_W'($urandom_range(free_blocks + 1, 255));
                else if (pick >= 93)
                begin
                    op    = 1'($urandom_range(0, 1));
                    owner = FIELD_W'($urandom_range(0, 255));
                    need  = FIELD_W'($urandom_range(0, 255));
                end
                send_request(op, owner, need, 1'b0, NO_WANT);
            end
        end

        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("[clustered_block_allocator_unit] OK");
        else
            $display("[clustered_block_allocator_unit] ERROR");
        $finish;
    end

endmodule

### clustered_block_allocator_unit.f
rtl/cba_pkg.sv
rtl/cba_req_if.sv
rtl/cba_rsp_if.sv
rtl/cba_ram.sv
rtl/cba_ctrl.sv
rtl/cba_dp.sv
rtl/clustered_block_allocator_unit.sv
rtl/cba_checker.sv
test/tb_clustered_block_allocator_unit.sv
